// ===== sv/rsc_pkg.sv =====
// Shared types, codes and decode helpers for the three-stage core.
package rsc_pkg;

    localparam int MEM_BYTES_DEF = 65536;

    localparam logic [2:0] ERR_NONE  = 3'd0;
    localparam logic [2:0] ERR_UNSUP = 3'd1;
    localparam logic [2:0] ERR_REG   = 3'd2;
    localparam logic [2:0] ERR_STORE = 3'd3;
    localparam logic [2:0] ERR_FETCH = 3'd4;

    localparam logic [1:0] FN_WRITE = 2'd0;
    localparam logic [1:0] FN_RUN   = 2'd1;
    localparam logic [1:0] FN_RDREG = 2'd2;
    localparam logic [1:0] FN_RDMEM = 2'd3;

    localparam logic [3:0] R_PC      = 4'd15;
    localparam logic [3:0] R_SP      = 4'd13;
    localparam logic [3:0] R_LR      = 4'd14;
    localparam logic [4:0] IDX_FLAGS = 5'd16;
    localparam int         NUM_GPR   = 13;

    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ASR = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    localparam logic [3:0] OP_AND = 4'd0;
    localparam logic [3:0] OP_EOR = 4'd1;
    localparam logic [3:0] OP_SUB = 4'd2;
    localparam logic [3:0] OP_RSB = 4'd3;
    localparam logic [3:0] OP_ADD = 4'd4;
    localparam logic [3:0] OP_TST = 4'd8;
    localparam logic [3:0] OP_TEQ = 4'd9;
    localparam logic [3:0] OP_CMP = 4'd10;
    localparam logic [3:0] OP_ORR = 4'd12;
    localparam logic [3:0] OP_MOV = 4'd13;

    localparam logic [3:0] CC_EQ = 4'd0;
    localparam logic [3:0] CC_NE = 4'd1;
    localparam logic [3:0] CC_GE = 4'd10;
    localparam logic [3:0] CC_LT = 4'd11;
    localparam logic [3:0] CC_GT = 4'd12;
    localparam logic [3:0] CC_LE = 4'd13;
    localparam logic [3:0] CC_AL = 4'd14;

    typedef enum logic [2:0] {
        K_ZERO = 3'd0,
        K_DP   = 3'd1,
        K_MUL  = 3'd2,
        K_SDT  = 3'd3,
        K_BR   = 3'd4,
        K_BAD  = 3'd5
    } kind_t;

    typedef enum logic [15:0] {
        S_CLEAR   = 16'h0001,
        S_IDLE    = 16'h0002,
        S_EXEC    = 16'h0004,
        S_RREG    = 16'h0008,
        S_SHIFT   = 16'h0010,
        S_ALU     = 16'h0020,
        S_LDWB    = 16'h0040,
        S_POST    = 16'h0080,
        S_DECODE  = 16'h0100,
        S_FETCHED = 16'h0200,
        S_MRD     = 16'h0400,
        S_MWR     = 16'h0800,
        S_REGRD   = 16'h1000,
        S_REGCAP  = 16'h2000,
        S_RDOUT   = 16'h4000,
        S_DONE    = 16'h8000
    } state_t;

    function automatic kind_t classify(input logic [31:0] w);
        kind_t k;
        if (w[22:21] == 2'b00 && w[27:26] == 2'b01)
            k = K_SDT;
        else if (w[27:24] == 4'hA)
            k = K_BR;
        else if (w[27:22] == 6'd0 && w[7:4] == 4'h9)
            k = K_MUL;
        else if (w[27:26] == 2'b00)
            k = (w != 32'd0) ? K_DP : K_ZERO;
        else
            k = K_BAD;
        return k;
    endfunction

    function automatic logic reg_ok(input logic [3:0] r);
        return r != R_SP && r != R_LR;
    endfunction

    // bit 1: unknown condition, bit 0: pass
    function automatic logic [1:0] cond_eval(input logic [3:0] c, input logic [3:0] f);
        logic n;
        logic z;
        logic v;
        logic [1:0] r;
        n = f[3];
        z = f[2];
        v = f[0];
        r = 2'b00;
        case (c)
            CC_EQ: r = {1'b0, z};
            CC_NE: r = {1'b0, !z};
            CC_GE: r = {1'b0, n == v};
            CC_LT: r = {1'b0, n != v};
            CC_GT: r = {1'b0, !z && n == v};
            CC_LE: r = {1'b0, z || n != v};
            CC_AL: r = 2'b01;
            default: r = 2'b10;
        endcase
        return r;
    endfunction

    function automatic logic op_known(input logic [3:0] op);
        return op == OP_AND || op == OP_EOR || op == OP_SUB || op == OP_RSB ||
               op == OP_ADD || op == OP_TST || op == OP_TEQ || op == OP_CMP ||
               op == OP_ORR || op == OP_MOV;
    endfunction

    function automatic logic op_writes(input logic [3:0] op);
        return op < OP_TST || op > OP_CMP;
    endfunction

    // errors known from register fields and opcode alone
    function automatic logic [2:0] idx_err(input logic [31:0] w, input kind_t k);
        logic [2:0] e;
        e = ERR_NONE;
        if (k == K_DP) begin
            if (!reg_ok(w[19:16]))
                e = ERR_REG;
            else if (!w[25] && !reg_ok(w[3:0]))
                e = ERR_REG;
            else if (!w[25] && w[4] && !reg_ok(w[11:8]))
                e = ERR_REG;
            else if (!op_known(w[24:21]))
                e = ERR_UNSUP;
            else if (op_writes(w[24:21]) && !reg_ok(w[15:12]))
                e = ERR_REG;
        end else if (k == K_MUL) begin
            if (w[21] && !reg_ok(w[15:12]))
                e = ERR_REG;
            else if (!reg_ok(w[3:0]) || !reg_ok(w[11:8]) || !reg_ok(w[19:16]))
                e = ERR_REG;
        end else if (k == K_SDT) begin
            if (w[25] && !reg_ok(w[3:0]))
                e = ERR_REG;
            else if (w[25] && w[4] && !reg_ok(w[11:8]))
                e = ERR_REG;
            else if (!reg_ok(w[19:16]))
                e = ERR_REG;
            else if (!w[20] && !reg_ok(w[15:12]))
                e = ERR_REG;
        end
        return e;
    endfunction

    // {carry, value}
    function automatic logic [32:0] shift_op(input logic [31:0] x, input logic [4:0] n,
                                             input logic [1:0] t);
        logic [31:0] v;
        logic [31:0] lo;
        logic [31:0] hi;
        logic        c;
        lo = x >> (n - 5'd1);
        hi = x >> (5'd0 - n);
        c  = lo[0];
        v  = x;
        case (t)
            SH_LSL:
            begin
                v = x << n;
                c = hi[0];
            end
            SH_LSR: v = x >> n;
            SH_ASR: v = 32'($signed(x) >>> n);
            default: v = (x >> n) | (x << (5'd0 - n));
        endcase
        if (n == 5'd0)
            return {1'b0, x};
        return {c, v};
    endfunction

endpackage

// ===== sv/risc_subset_core_step.sv =====
// Three-stage core for a small 32-bit instruction subset, run one word at a time.
// A run request executes the decoded word, if any, then fetches the next one; out-of-range accesses and runs
// while halted go straight to the response (one memory byte and one register read a cycle).
// Throughput: one word at a time; the next word is taken once the block is back in idle.
// Reset: control clears at once; then the memory is zeroed byte by byte with in_stall high.
module risc_subset_core_step #(
    parameter int MEM_BYTES = rsc_pkg::MEM_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [15:0] address,
    input  logic [31:0] data_in,
    input  logic [4:0]  reg_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] read_data,
    output logic [31:0] pc_value,
    output logic        halted,
    output logic [2:0]  error_code,
    output logic        load_skipped
);
    import rsc_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);

    state_t        state_reg, state_next, ret_reg, ret_next;
    logic [2:0]    cnt_reg, cnt_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [AW-1:0] base_reg, base_next;
    logic [31:0]   pc_reg, pc_next;
    logic [3:0]    flags_reg, flags_next;
    logic [31:0]   fw_reg, fw_next, dw_reg, dw_next;
    logic          fv_reg, fv_next, dv_reg, dv_next;
    logic          halt_reg, halt_next;
    logic [2:0]    code_reg, code_next;
    logic          skip_reg, skip_next;
    logic [4:0]    idx_reg, idx_next;
    logic [31:0]   data_reg, data_next;
    logic [31:0]   rdata_reg, rdata_next;
    logic [31:0]   x_reg, x_next, s_reg, s_next, a_reg, a_next, d_reg, d_next;
    logic [31:0]   b_reg, b_next, moved_reg, moved_next;
    logic          c_reg, c_next;
    logic          out_valid_reg, out_valid_next;
    logic [31:0]   o_rdata_reg, o_rdata_next, o_pc_reg, o_pc_next;
    logic          o_halt_reg, o_halt_next, o_skip_reg, o_skip_next;
    logic [2:0]    o_code_reg, o_code_next;

    logic [31:0]   gpr [NUM_GPR];
    logic [3:0]    rf_raddr;
    logic [31:0]   rf_q;
    logic [31:0]   rf_q_next_sel;
    logic          wr_en;
    logic [3:0]    wr_idx;
    logic [31:0]   wr_val;
    logic          rf_we;

    logic [7:0]    mem [MEM_BYTES];
    logic          mem_we;
    logic [AW-1:0] mem_widx, mem_ridx;
    logic [7:0]    mem_wdata, mem_q;

    function automatic logic in_range(input logic [31:0] a);
        return a <= 32'(MEM_BYTES - 4);
    endfunction

    assign in_stall     = state_reg != S_IDLE;
    assign out_valid    = out_valid_reg;
    assign read_data    = o_rdata_reg;
    assign pc_value     = o_pc_reg;
    assign halted       = o_halt_reg;
    assign error_code   = o_code_reg;
    assign load_skipped = o_skip_reg;
    assign rf_we        = wr_en && wr_idx != R_PC;

    always_comb
    begin
        kind_t       kind;
        logic [1:0]  ce;
        logic [2:0]  e;
        logic [32:0] sh;
        logic [32:0] sum;
        logic [31:0] res;
        logic [31:0] off;
        logic [31:0] moved;
        logic [31:0] addr;
        logic        cc;

        state_next     = state_reg;
        ret_next       = ret_reg;
        cnt_next       = cnt_reg;
        clr_next       = clr_reg;
        base_next      = base_reg;
        pc_next        = pc_reg;
        flags_next     = flags_reg;
        fw_next        = fw_reg;
        fv_next        = fv_reg;
        dw_next        = dw_reg;
        dv_next        = dv_reg;
        halt_next      = halt_reg;
        code_next      = code_reg;
        skip_next      = skip_reg;
        idx_next       = idx_reg;
        data_next      = data_reg;
        rdata_next     = rdata_reg;
        x_next         = x_reg;
        s_next         = s_reg;
        a_next         = a_reg;
        d_next         = d_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        moved_next     = moved_reg;
        out_valid_next = out_valid_reg && out_stall;
        o_rdata_next   = o_rdata_reg;
        o_pc_next      = o_pc_reg;
        o_halt_next    = o_halt_reg;
        o_code_next    = o_code_reg;
        o_skip_next    = o_skip_reg;
        rf_raddr       = 4'd0;
        wr_en          = 1'b0;
        wr_idx         = 4'd0;
        wr_val         = 32'd0;
        mem_we         = 1'b0;
        mem_widx       = base_reg + AW'(cnt_reg[1:0]);
        mem_wdata      = data_reg[7:0];
        mem_ridx       = base_reg + AW'(cnt_reg[1:0]);
        kind           = classify(dw_reg);
        ce             = cond_eval(dw_reg[31:28], flags_reg);
        e              = idx_err(dw_reg, kind);
        sh             = 33'd0;
        sum            = 33'd0;
        res            = 32'd0;
        cc             = c_reg;
        off            = dw_reg[25] ? b_reg : {20'd0, dw_reg[11:0]};
        moved          = dw_reg[23] ? a_reg + off : a_reg - off;
        addr           = dw_reg[24] ? moved : a_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_widx  = clr_reg;
                mem_wdata = 8'd0;
                if (clr_reg == AW'(MEM_BYTES - 1))
                    state_next = S_IDLE;
                else
                    clr_next = clr_reg + AW'(1);
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    rdata_next = 32'd0;
                    skip_next  = 1'b0;
                    cnt_next   = 3'd0;
                    base_next  = AW'(address);
                    idx_next   = reg_index;
                    state_next = S_DONE;
                    unique case (func)
                        FN_WRITE:
                        begin
                            if (in_range({16'd0, address}))
                            begin
                                data_next  = data_in;
                                ret_next   = S_DONE;
                                state_next = S_MWR;
                            end
                        end
                        FN_RUN:
                        begin
                            if (!halt_reg)
                                state_next = dv_reg ? S_EXEC : S_DECODE;
                        end
                        FN_RDREG: state_next = S_REGRD;
                        default:
                        begin
                            if (in_range({16'd0, address}))
                            begin
                                ret_next   = S_RDOUT;
                                state_next = S_MRD;
                            end
                        end
                    endcase
                end
            end
            S_EXEC:
            begin
                if (kind == K_ZERO)
                begin
                    halt_next  = 1'b1;
                    code_next  = ERR_NONE;
                    state_next = S_DONE;
                end
                else if (ce[1] || (ce[0] && kind == K_BAD))
                begin
                    halt_next  = 1'b1;
                    code_next  = ERR_UNSUP;
                    state_next = S_DONE;
                end
                else if (!ce[0])
                    state_next = S_DECODE;
                else if (kind == K_BR)
                begin
                    pc_next    = pc_reg + {{6{dw_reg[23]}}, dw_reg[23:0], 2'b00};
                    fv_next    = 1'b0;
                    dv_next    = 1'b0;
                    state_next = S_DECODE;
                end
                else if (e != ERR_NONE)
                begin
                    halt_next  = 1'b1;
                    code_next  = e;
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next   = 3'd0;
                    state_next = S_RREG;
                end
            end
            S_RREG:
            begin
                cnt_next = cnt_reg + 3'd1;
                unique case (cnt_reg)
                    3'd0: rf_raddr = dw_reg[3:0];
                    3'd1:
                    begin
                        x_next   = rf_q;
                        rf_raddr = dw_reg[11:8];
                    end
                    3'd2:
                    begin
                        s_next   = rf_q;
                        rf_raddr = dw_reg[19:16];
                    end
                    3'd3:
                    begin
                        a_next   = rf_q;
                        rf_raddr = dw_reg[15:12];
                    end
                    default:
                    begin
                        d_next     = rf_q;
                        state_next = S_SHIFT;
                    end
                endcase
            end
            S_SHIFT:
            begin
                if (kind == K_DP && dw_reg[25])
                    sh = shift_op({24'd0, dw_reg[7:0]}, {dw_reg[11:8], 1'b0}, SH_ROR);
                else
                    sh = shift_op(x_reg, dw_reg[4] ? {1'b0, s_reg[3:0]} : dw_reg[11:7],
                                  dw_reg[6:5]);
                if (kind == K_MUL)
                    b_next = x_reg * s_reg;
                else
                begin
                    b_next = sh[31:0];
                    c_next = sh[32];
                end
                state_next = S_ALU;
            end
            S_ALU:
            begin
                state_next = S_DECODE;
                if (kind == K_MUL)
                begin
                    res    = b_reg + (dw_reg[21] ? d_reg : 32'd0);
                    wr_en  = 1'b1;
                    wr_idx = dw_reg[19:16];
                    wr_val = res;
                    if (dw_reg[20])
                        flags_next = {res[31], res == 32'd0, flags_reg[1:0]};
                end
                else if (kind == K_SDT)
                begin
                    moved_next = moved;
                    base_next  = AW'(addr);
                    cnt_next   = 3'd0;
                    if (dw_reg[20])
                    begin
                        if (!in_range(addr))
                        begin
                            skip_next = 1'b1;
                            if (!dw_reg[24])
                            begin
                                wr_en  = 1'b1;
                                wr_idx = dw_reg[19:16];
                                wr_val = moved;
                            end
                        end
                        else if (!reg_ok(dw_reg[15:12]))
                        begin
                            halt_next  = 1'b1;
                            code_next  = ERR_REG;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            ret_next   = S_LDWB;
                            state_next = S_MRD;
                        end
                    end
                    else if (!in_range(addr))
                    begin
                        halt_next  = 1'b1;
                        code_next  = ERR_STORE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        data_next  = d_reg;
                        ret_next   = dw_reg[24] ? S_DECODE : S_POST;
                        state_next = S_MWR;
                    end
                end
                else
                begin
                    sum = {1'b0, a_reg} + {1'b0, b_reg};
                    unique case (dw_reg[24:21])
                        OP_AND, OP_TST: res = a_reg & b_reg;
                        OP_EOR, OP_TEQ: res = a_reg ^ b_reg;
                        OP_SUB, OP_CMP:
                        begin
                            cc  = b_reg <= a_reg;
                            res = a_reg - b_reg;
                        end
                        OP_RSB:
                        begin
                            cc  = a_reg <= b_reg;
                            res = b_reg - a_reg;
                        end
                        OP_ADD:
                        begin
                            cc  = sum[32];
                            res = sum[31:0];
                        end
                        OP_ORR: res = a_reg | b_reg;
                        OP_MOV: res = b_reg;
                        default: res = 32'd0;
                    endcase
                    if (op_writes(dw_reg[24:21]))
                    begin
                        wr_en  = 1'b1;
                        wr_idx = dw_reg[15:12];
                        wr_val = res;
                    end
                    if (dw_reg[20])
                        flags_next = {res[31], res == 32'd0, cc, flags_reg[0]};
                end
            end
            S_LDWB:
            begin
                wr_en      = 1'b1;
                wr_idx     = dw_reg[15:12];
                wr_val     = data_reg;
                state_next = dw_reg[24] ? S_DECODE : S_POST;
            end
            S_POST:
            begin
                wr_en      = 1'b1;
                wr_idx     = dw_reg[19:16];
                wr_val     = moved_reg;
                state_next = S_DECODE;
            end
            S_DECODE:
            begin
                if (fv_reg && classify(fw_reg) == K_BAD)
                begin
                    halt_next  = 1'b1;
                    code_next  = ERR_UNSUP;
                    state_next = S_DONE;
                end
                else
                begin
                    if (fv_reg)
                    begin
                        dw_next = fw_reg;
                        dv_next = 1'b1;
                    end
                    if (!in_range(pc_reg))
                    begin
                        halt_next  = 1'b1;
                        code_next  = ERR_FETCH;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        base_next  = AW'(pc_reg);
                        cnt_next   = 3'd0;
                        ret_next   = S_FETCHED;
                        state_next = S_MRD;
                    end
                end
            end
            S_FETCHED:
            begin
                fw_next    = data_reg;
                fv_next    = 1'b1;
                pc_next    = pc_reg + 32'd4;
                state_next = S_DONE;
            end
            S_MRD:
            begin
                if (cnt_reg != 3'd0)
                    data_next = {mem_q, data_reg[31:8]};
                if (cnt_reg == 3'd4)
                    state_next = ret_reg;
                else
                    cnt_next = cnt_reg + 3'd1;
            end
            S_MWR:
            begin
                mem_we    = 1'b1;
                data_next = data_reg >> 8;
                if (cnt_reg == 3'd3)
                    state_next = ret_reg;
                else
                    cnt_next = cnt_reg + 3'd1;
            end
            S_REGRD:
            begin
                rf_raddr   = idx_reg[3:0];
                state_next = S_REGCAP;
            end
            S_REGCAP:
            begin
                if (idx_reg == IDX_FLAGS)
                    rdata_next = {flags_reg, 28'd0};
                else if (!idx_reg[4] && reg_ok(idx_reg[3:0]))
                    rdata_next = rf_q;
                state_next = S_DONE;
            end
            S_RDOUT:
            begin
                rdata_next = data_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    o_rdata_next   = rdata_reg;
                    o_pc_next      = pc_reg;
                    o_halt_next    = halt_reg;
                    o_code_next    = code_reg;
                    o_skip_next    = skip_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (wr_en && wr_idx == R_PC)
            pc_next = wr_val;
    end

    always_comb
    begin
        if (rf_raddr == R_PC)
            rf_q_next_sel = pc_reg;
        else if (rf_raddr < 4'(NUM_GPR))
            rf_q_next_sel = gpr[rf_raddr];
        else
            rf_q_next_sel = 32'd0;
    end

    always_ff @(posedge clk)
    begin
        rf_q <= rf_q_next_sel;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_widx] <= mem_wdata;
        mem_q <= mem[mem_ridx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_GPR; i++)
                gpr[i] <= 32'd0;
        end
        else if (rf_we && wr_idx < 4'(NUM_GPR))
            gpr[wr_idx] <= wr_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            ret_reg       <= S_DONE;
            cnt_reg       <= 3'd0;
            clr_reg       <= '0;
            pc_reg        <= 32'd0;
            flags_reg     <= 4'd0;
            fw_reg        <= 32'd0;
            fv_reg        <= 1'b0;
            dw_reg        <= 32'd0;
            dv_reg        <= 1'b0;
            halt_reg      <= 1'b0;
            code_reg      <= ERR_NONE;
            skip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            cnt_reg       <= cnt_next;
            clr_reg       <= clr_next;
            pc_reg        <= pc_next;
            flags_reg     <= flags_next;
            fw_reg        <= fw_next;
            fv_reg        <= fv_next;
            dw_reg        <= dw_next;
            dv_reg        <= dv_next;
            halt_reg      <= halt_next;
            code_reg      <= code_next;
            skip_reg      <= skip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg    <= base_next;
        idx_reg     <= idx_next;
        data_reg    <= data_next;
        rdata_reg   <= rdata_next;
        x_reg       <= x_next;
        s_reg       <= s_next;
        a_reg       <= a_next;
        d_reg       <= d_next;
        b_reg       <= b_next;
        c_reg       <= c_next;
        moved_reg   <= moved_next;
        o_rdata_reg <= o_rdata_next;
        o_pc_reg    <= o_pc_next;
        o_halt_reg  <= o_halt_next;
        o_code_reg  <= o_code_next;
        o_skip_reg  <= o_skip_next;
    end

endmodule
